FILE: rtl/urtb_pkg.sv
// Package for the uart receive/transmit ring buffer block.
// Holds request codes, controller state type, control structs and default sizes.
// No dependencies.
package urtb_pkg;

	// default fifo depths
	localparam int RX_DEPTH_DEF = 16;
	localparam int TX_DEPTH_DEF = 256;

	// payload widths
	localparam int BYTE_W     = 8;
	localparam int REQ_TYPE_W = 3;

	// request codes carried on req_type
	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_HOST_SEND   = 3'd0,
		REQ_HOST_RECV   = 3'd1,
		REQ_LINE_BYTE   = 3'd2,
		REQ_TX_READY    = 3'd3,
		REQ_TX_COMPLETE = 3'd4
	} req_kind_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_busy;
		logic out_taken;
	} dp_status_t;

endpackage

FILE: rtl/urtb_if.sv
// Valid/ready channel interfaces for the uart ring buffer block.
// Depends on urtb_pkg for payload widths.
interface urtb_req_if
	import urtb_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [BYTE_W-1:0]     data_byte;
	logic                  rx_error;

	modport source (output valid, req_type, data_byte, rx_error, input ready);
	modport sink   (input valid, req_type, data_byte, rx_error, output ready);
endinterface

interface urtb_rsp_if
	import urtb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              accepted;
	logic [BYTE_W-1:0] host_byte;
	logic              line_send;
	logic [BYTE_W-1:0] line_byte;
	logic              tx_event_enabled;
	logic              tx_done;

	modport source (output valid, accepted, host_byte, line_send, line_byte,
		tx_event_enabled, tx_done, input ready);
	modport sink   (input valid, accepted, host_byte, line_send, line_byte,
		tx_event_enabled, tx_done, output ready);
endinterface

FILE: rtl/uart_rx_tx_ring_buffers.sv
// Top level of the uart receive/transmit ring buffer block.
// Instantiates urtb_ctrl and urtb_dp; depends on urtb_pkg and urtb_if.
//
// Usage:
//   req is a valid/ready channel; each transaction is one event: host send,
//   host receive, line byte received, transmitter ready or transmit complete.
//   rsp is a valid/ready channel that returns exactly one result per event:
//   accept flag, popped host byte, byte for the line, and the transmitter
//   event enable and transmit-done flags as they stand after the event.
// Sequence:
//   an event is taken in the capture cycle, in which both fifo memories are read
//   at their read pointers into registers; in the execute state, once the result
//   register is free, pointers, flags and memory are updated and the result
//   register is loaded, which also sets rsp valid. No new event is taken before
//   that, as the registered memory read comes ahead of the update.
// Reset:
//   arst_n clears pointers, full flags, the event enable and the done flag;
//   fifo contents are not cleared and need no clearing pass.
// Stall:
//   a result waits in the output register while rsp.ready is low; one more
//   event is still taken and then holds until the result register drains.
module uart_rx_tx_ring_buffers
	import urtb_pkg::*;
#(
	parameter int RxDepth = RX_DEPTH_DEF,
	parameter int TxDepth = TX_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	urtb_req_if.sink   req,
	urtb_rsp_if.source rsp
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// controller
	urtb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	urtb_dp #(
		.RxDepth (RxDepth),
		.TxDepth (TxDepth)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.req_type         (req.req_type),
		.data_byte        (req.data_byte),
		.rx_error         (req.rx_error),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.accepted         (rsp.accepted),
		.host_byte        (rsp.host_byte),
		.line_send        (rsp.line_send),
		.line_byte        (rsp.line_byte),
		.tx_event_enabled (rsp.tx_event_enabled),
		.tx_done          (rsp.tx_done)
	);

endmodule

FILE: rtl/urtb_ctrl.sv
// Controller state machine for the uart ring buffer block.
// Sequences capture and execute of one transaction; depends on urtb_pkg.
module urtb_ctrl
	import urtb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_next;
	logic        out_free;

	// result register can take a new result this cycle
	assign out_free = !status.out_busy || status.out_taken;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.execute = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/urtb_dp.sv
// Datapath for the uart ring buffer block: both fifo memories, pointers,
// flags and the result register. Depends on urtb_pkg.
module urtb_dp
	import urtb_pkg::*;
#(
	parameter int RxDepth = RX_DEPTH_DEF,
	parameter int TxDepth = TX_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic [REQ_TYPE_W-1:0] req_type,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  rx_error,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic [BYTE_W-1:0]     host_byte,
	output logic                  line_send,
	output logic [BYTE_W-1:0]     line_byte,
	output logic                  tx_event_enabled,
	output logic                  tx_done
);

	localparam int RX_AW = $clog2(RxDepth);
	localparam int TX_AW = $clog2(TxDepth);
	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RxDepth - 1);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TxDepth - 1);

	// fifo memories
	logic [BYTE_W-1:0] rx_mem [RxDepth];
	logic [BYTE_W-1:0] tx_mem [TxDepth];
	logic [BYTE_W-1:0] rx_rdata_q;
	logic [BYTE_W-1:0] tx_rdata_q;

	// captured request
	logic [REQ_TYPE_W-1:0] req_type_q;
	logic [BYTE_W-1:0]     data_q;
	logic                  err_q;

	// pointers and flags
	logic [RX_AW-1:0] rx_rd_ptr_q, rx_wr_ptr_q;
	logic [TX_AW-1:0] tx_rd_ptr_q, tx_wr_ptr_q;
	logic             rx_full_q, tx_full_q, tx_en_q, tx_done_q;

	// next values
	logic [RX_AW-1:0]  rx_rd_ptr_n, rx_wr_ptr_n, rx_rd_inc, rx_wr_inc;
	logic [TX_AW-1:0]  tx_rd_ptr_n, tx_wr_ptr_n, tx_rd_inc, tx_wr_inc;
	logic              rx_full_n, tx_full_n, tx_en_n, tx_done_n;
	logic              rx_we, tx_we, rx_empty, tx_empty;
	logic              acc_n, lsend_n;
	logic [BYTE_W-1:0] hbyte_n, lbyte_n;

	// result register
	logic              out_valid_q;
	logic              acc_q, lsend_q;
	logic [BYTE_W-1:0] hbyte_q, lbyte_q;

	assign status.out_busy  = out_valid_q;
	assign status.out_taken = out_valid_q && out_ready;

	// capture request and read both fifos at their read pointers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			data_q     <= data_byte;
			err_q      <= rx_error;
			rx_rdata_q <= rx_mem[rx_rd_ptr_q];
			tx_rdata_q <= tx_mem[tx_rd_ptr_q];
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.execute && rx_we) begin
			rx_mem[rx_wr_ptr_q] <= data_q;
		end
		if (cmd.execute && tx_we) begin
			tx_mem[tx_wr_ptr_q] <= data_q;
		end
	end

	// wrapping pointer increments
	assign rx_rd_inc = (rx_rd_ptr_q == RX_LAST) ? '0 : rx_rd_ptr_q + RX_AW'(1);
	assign rx_wr_inc = (rx_wr_ptr_q == RX_LAST) ? '0 : rx_wr_ptr_q + RX_AW'(1);
	assign tx_rd_inc = (tx_rd_ptr_q == TX_LAST) ? '0 : tx_rd_ptr_q + TX_AW'(1);
	assign tx_wr_inc = (tx_wr_ptr_q == TX_LAST) ? '0 : tx_wr_ptr_q + TX_AW'(1);
	assign rx_empty  = (rx_rd_ptr_q == rx_wr_ptr_q) && !rx_full_q;
	assign tx_empty  = (tx_rd_ptr_q == tx_wr_ptr_q) && !tx_full_q;

	// event decode
	always_comb begin
		rx_rd_ptr_n = rx_rd_ptr_q;
		rx_wr_ptr_n = rx_wr_ptr_q;
		rx_full_n   = rx_full_q;
		tx_rd_ptr_n = tx_rd_ptr_q;
		tx_wr_ptr_n = tx_wr_ptr_q;
		tx_full_n   = tx_full_q;
		tx_en_n     = tx_en_q;
		tx_done_n   = tx_done_q;
		rx_we       = 1'b0;
		tx_we       = 1'b0;
		acc_n       = 1'b0;
		lsend_n     = 1'b0;
		hbyte_n     = '0;
		lbyte_n     = '0;
		case (req_type_q)
			REQ_HOST_SEND: begin
				if (!tx_full_q) begin
					tx_we       = 1'b1;
					tx_wr_ptr_n = tx_wr_inc;
					tx_full_n   = (tx_wr_inc == tx_rd_ptr_q);
					tx_done_n   = 1'b0;
					tx_en_n     = 1'b1;
					acc_n       = 1'b1;
				end
			end
			REQ_HOST_RECV: begin
				if (!rx_empty) begin
					hbyte_n     = rx_rdata_q;
					rx_rd_ptr_n = rx_rd_inc;
					rx_full_n   = 1'b0;
					acc_n       = 1'b1;
				end
			end
			REQ_LINE_BYTE: begin
				if (!err_q && !rx_full_q) begin
					rx_we       = 1'b1;
					rx_wr_ptr_n = rx_wr_inc;
					rx_full_n   = (rx_wr_inc == rx_rd_ptr_q);
				end
			end
			REQ_TX_READY: begin
				if (tx_en_q) begin
					if (!tx_empty) begin
						lbyte_n     = tx_rdata_q;
						tx_rd_ptr_n = tx_rd_inc;
						tx_full_n   = 1'b0;
						lsend_n     = 1'b1;
					end else begin
						tx_en_n = 1'b0;
					end
				end
			end
			REQ_TX_COMPLETE: begin
				tx_done_n = 1'b1;
			end
			default: begin
				acc_n = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_rd_ptr_q <= '0;
			rx_wr_ptr_q <= '0;
			rx_full_q   <= 1'b0;
			tx_rd_ptr_q <= '0;
			tx_wr_ptr_q <= '0;
			tx_full_q   <= 1'b0;
			tx_en_q     <= 1'b0;
			tx_done_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.execute) begin
				rx_rd_ptr_q <= rx_rd_ptr_n;
				rx_wr_ptr_q <= rx_wr_ptr_n;
				rx_full_q   <= rx_full_n;
				tx_rd_ptr_q <= tx_rd_ptr_n;
				tx_wr_ptr_q <= tx_wr_ptr_n;
				tx_full_q   <= tx_full_n;
				tx_en_q     <= tx_en_n;
				tx_done_q   <= tx_done_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			acc_q   <= acc_n;
			hbyte_q <= hbyte_n;
			lsend_q <= lsend_n;
			lbyte_q <= lbyte_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = acc_q;
	assign host_byte        = hbyte_q;
	assign line_send        = lsend_q;
	assign line_byte        = lbyte_q;
	assign tx_event_enabled = tx_en_q;
	assign tx_done          = tx_done_q;

endmodule

FILE: dv/tb_uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_rx_tx_ring_buffers: random and directed events
// through the req channel, every result checked against an in-bench ring buffer model.
// Depends on urtb_pkg, urtb_req_if, urtb_rsp_if and the block's rtl.
module tb_uart_rx_tx_ring_buffers;
	import urtb_pkg::*;

	localparam int RXD        = RX_DEPTH_DEF;
	localparam int TXD        = TX_DEPTH_DEF;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 300;
	localparam int ITEM_GOAL  = 1050;
	localparam int TAIL_WAIT  = 10;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_LO  = 3'd5;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_MID = 3'd6;
	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED_HI  = 3'd7;

	typedef struct {
		logic [REQ_TYPE_W-1:0] kind;
		logic [BYTE_W-1:0]     data;
		logic                  err;
		bit                    drain_first;
	} uart_event_t;

	typedef struct {
		logic              accepted;
		logic [BYTE_W-1:0] host_byte;
		logic              line_send;
		logic [BYTE_W-1:0] line_byte;
		logic              tx_event_enabled;
		logic              tx_done;
	} uart_result_t;

	logic clk = 1'b0;
	logic arst_n;

	urtb_req_if req_ch ();
	urtb_rsp_if rsp_ch ();

	uart_rx_tx_ring_buffers dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ring buffer model state
	logic [BYTE_W-1:0]        rx_mem [RXD];
	logic [$clog2(RXD)-1:0]   rx_rd = '0;
	logic [$clog2(RXD)-1:0]   rx_wr = '0;
	logic                     rx_full = 1'b0;
	logic [BYTE_W-1:0]        tx_mem [TXD];
	logic [$clog2(TXD)-1:0]   tx_rd = '0;
	logic [$clog2(TXD)-1:0]   tx_wr = '0;
	logic                     tx_full = 1'b0;
	logic                     tx_ev_on = 1'b0;
	logic                     tx_cmpl = 1'b0;

	uart_event_t  host_line_events [$];
	uart_result_t pending_results [$];
	int           n_errors = 0;
	int           n_results = 0;
	int           n_cycles = 0;

	// apply one event to the model and return the result it produces
	function automatic uart_result_t next_uart_result(uart_event_t ev);
		uart_result_t r;
		r = '{default: '0};
		case (ev.kind)
			REQ_HOST_SEND: begin
				if (!tx_full) begin
					tx_mem[tx_wr] = ev.data;
					tx_wr = (tx_wr == TXD - 1) ? '0 : tx_wr + 1'b1;
					if (tx_wr == tx_rd)
						tx_full = 1'b1;
					tx_cmpl = 1'b0;
					tx_ev_on = 1'b1;
					r.accepted = 1'b1;
				end
			end
			REQ_HOST_RECV: begin
				if (rx_rd != rx_wr || rx_full) begin
					r.host_byte = rx_mem[rx_rd];
					rx_rd = (rx_rd == RXD - 1) ? '0 : rx_rd + 1'b1;
					rx_full = 1'b0;
					r.accepted = 1'b1;
				end
			end
			REQ_LINE_BYTE: begin
				if (!ev.err && !rx_full) begin
					rx_mem[rx_wr] = ev.data;
					rx_wr = (rx_wr == RXD - 1) ? '0 : rx_wr + 1'b1;
					if (rx_wr == rx_rd)
						rx_full = 1'b1;
				end
			end
			REQ_TX_READY: begin
				if (tx_ev_on) begin
					if (tx_rd != tx_wr || tx_full) begin
						r.line_byte = tx_mem[tx_rd];
						tx_rd = (tx_rd == TXD - 1) ? '0 : tx_rd + 1'b1;
						tx_full = 1'b0;
						r.line_send = 1'b1;
					end else begin
						tx_ev_on = 1'b0;
					end
				end
			end
			REQ_TX_COMPLETE: begin
				tx_cmpl = 1'b1;
			end
			default: begin
			end
		endcase
		r.tx_event_enabled = tx_ev_on;
		r.tx_done = tx_cmpl;
		return r;
	endfunction

	task automatic add_event(logic [REQ_TYPE_W-1:0] kind, logic [BYTE_W-1:0] data,
		logic err, bit drain_first = 1'b0);
		uart_event_t ev;
		ev.kind = kind;
		ev.data = data;
		ev.err = err;
		ev.drain_first = drain_first;
		host_line_events.push_back(ev);
	endtask

	task automatic check_field(string name, logic [BYTE_W-1:0] exp, logic [BYTE_W-1:0] act);
		if (act !== exp) begin
			$display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp, act);
			n_errors++;
		end
	endtask

	// driver: presents queued events, random gaps, optional drain before an event
	int gap_left = 0;
	int n_sent = 0;
	bit src_quiet = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		uart_event_t nxt;
		uart_event_t seen;
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.req_type  <= '0;
			req_ch.data_byte <= '0;
			req_ch.rx_error  <= 1'b0;
		end else begin
			// transaction taken this edge: predict its result
			if (req_ch.valid && req_ch.ready) begin
				seen.kind = req_ch.req_type;
				seen.data = req_ch.data_byte;
				seen.err = req_ch.rx_error;
				seen.drain_first = 1'b0;
				pending_results.push_back(next_uart_result(seen));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (host_line_events.size() != 0 &&
					!(host_line_events[0].drain_first && pending_results.size() != 0)) begin
					nxt = host_line_events.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.req_type  <= nxt.kind;
					req_ch.data_byte <= nxt.data;
					req_ch.rx_error  <= nxt.err;
					gap_left = src_quiet ? 0 : $urandom_range(0, 3);
					n_sent++;
					if (n_sent % 40 == 0)
						src_quiet = ($urandom_range(0, 2) == 0);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random ready stalls, one long hold, field compare
	int rdy_wait = 0;
	bit dst_quiet = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		uart_result_t exp;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual acc=%0b hb=%0h ls=%0b lb=%0h",
						$time, rsp_ch.accepted, rsp_ch.host_byte, rsp_ch.line_send,
						rsp_ch.line_byte);
					n_errors++;
				end else begin
					exp = pending_results.pop_front();
					check_field("accepted", BYTE_W'(exp.accepted), BYTE_W'(rsp_ch.accepted));
					check_field("host_byte", exp.host_byte, rsp_ch.host_byte);
					check_field("line_send", BYTE_W'(exp.line_send),
						BYTE_W'(rsp_ch.line_send));
					check_field("line_byte", exp.line_byte, rsp_ch.line_byte);
					check_field("tx_event_enabled", BYTE_W'(exp.tx_event_enabled),
						BYTE_W'(rsp_ch.tx_event_enabled));
					check_field("tx_done", BYTE_W'(exp.tx_done), BYTE_W'(rsp_ch.tx_done));
				end
				n_results++;
				if (n_results % 50 == 0)
					dst_quiet = ($urandom_range(0, 2) == 0);
				rdy_wait = dst_quiet ? 0 : $urandom_range(0, 3);
				// long hold so the block fills and backs up the request side
				if (n_results == HOLD_AT)
					rdy_wait = HOLD_LEN;
			end else if (rdy_wait > 0) begin
				rdy_wait--;
			end
			rsp_ch.ready <= (rdy_wait == 0);
		end
	end

	// cycle cap
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_CAP) begin
			$display("tb_uart_rx_tx_ring_buffers: errors");
			$finish;
		end
	end

	// stimulus and end of test
	initial begin
		int total;
		int n;
		int m;
		int pick;
		bit drain;
		logic [REQ_TYPE_W-1:0] k;

		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.data_byte = '0;
		req_ch.rx_error = 1'b0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;

		// directed: extremes, error drop, empty pops, disabled ready, unused codes
		add_event(REQ_LINE_BYTE, 8'h00, 1'b0);
		add_event(REQ_LINE_BYTE, 8'hFF, 1'b0);
		add_event(REQ_LINE_BYTE, 8'h5A, 1'b1);
		add_event(REQ_HOST_RECV, 8'hFF, 1'b1);
		add_event(REQ_HOST_RECV, 8'h00, 1'b0);
		add_event(REQ_HOST_RECV, 8'h00, 1'b0);
		add_event(REQ_TX_READY, 8'hFF, 1'b1);
		add_event(REQ_TX_COMPLETE, 8'hFF, 1'b1);
		add_event(REQ_HOST_SEND, 8'h00, 1'b0);
		add_event(REQ_HOST_SEND, 8'hFF, 1'b1);
		add_event(REQ_TX_READY, 8'h00, 1'b0);
		add_event(REQ_TX_READY, 8'h00, 1'b0);
		add_event(REQ_TX_READY, 8'h00, 1'b0);
		add_event(REQ_TX_READY, 8'hAA, 1'b1);
		add_event(REQ_TX_COMPLETE, 8'h00, 1'b0);
		add_event(REQ_UNUSED_LO, 8'hFF, 1'b1);
		add_event(REQ_UNUSED_MID, 8'h00, 1'b0);
		add_event(REQ_UNUSED_HI, 8'hA5, 1'b1);
		add_event(REQ_LINE_BYTE, 8'h81, 1'b0);
		add_event(REQ_HOST_RECV, 8'h3C, 1'b0);
		add_event(REQ_HOST_SEND, 8'h7E, 1'b0);
		add_event(REQ_TX_COMPLETE, 8'h00, 1'b0);

		// fill the transmit fifo past full, then drain it past empty
		for (int i = 0; i < TXD + 4; i++)
			add_event(REQ_HOST_SEND, BYTE_W'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), i == 0);
		for (int i = 0; i < TXD + 6; i++)
			add_event(REQ_TX_READY, BYTE_W'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));

		// random sequences
		total = host_line_events.size();
		while (total < ITEM_GOAL) begin
			pick = $urandom_range(0, 9);
			drain = ($urandom_range(0, 5) == 0);
			if (pick < 4) begin
				// receive burst: line bytes, some with errors, then host pops
				n = $urandom_range(1, 20);
				m = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					add_event(REQ_LINE_BYTE, BYTE_W'($urandom_range(0, 255)),
						$urandom_range(0, 7) == 0, drain && i == 0);
				for (int i = 0; i < m; i++)
					add_event(REQ_HOST_RECV, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				total += n + m;
			end else if (pick < 8) begin
				// transmit burst: host sends, ready events, maybe completion
				n = $urandom_range(1, 12);
				m = $urandom_range(1, 14);
				for (int i = 0; i < n; i++)
					add_event(REQ_HOST_SEND, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), drain && i == 0);
				for (int i = 0; i < m; i++)
					add_event(REQ_TX_READY, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				total += n + m;
				if ($urandom_range(0, 1)) begin
					add_event(REQ_TX_COMPLETE, BYTE_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					total += 1;
				end
			end else begin
				// noise: any code including unused ones
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					k = REQ_TYPE_W'($urandom_range(0, 7));
					add_event(k, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						drain && i == 0);
				end
				total += n;
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every transaction to go out and every result to come back
		while (host_line_events.size() != 0 || req_ch.valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (n_errors == 0) begin
			$display("tb_uart_rx_tx_ring_buffers: clean");
		end else begin
			$display("tb_uart_rx_tx_ring_buffers: errors");
		end
		$finish;
	end

endmodule
